[rtl/core/cle_pkg.sv]
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the C string literal escaper
// Word layouts for both channels, the classified entry passed from the
// front to the back, and character constants.
// ----------------------------------------------------------------------------
package cle_pkg;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] next_byte;
      logic       is_last;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [7:0] out_char;
      logic       is_terminator;
      logic       run_last;
   } rsp_word_type;

   // how the back end spells a byte
   typedef enum logic [2:0] {
      KIND_ZERO,       // \0 or \000
      KIND_SPECIAL,    // backslash + name
      KIND_PRINT,      // printable, not a hex digit
      KIND_PRINT_HEX,  // printable hex digit: escaped only after a hex escape
      KIND_HEX         // \x0hh
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;      // escape name for KIND_SPECIAL, raw byte otherwise
      logic       zero_long;  // zero byte followed by a decimal digit
      logic       is_last;
   } entry_type;

   localparam int Q_DEPTH = 2;
   localparam int SEQ_MAX = 5;

   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // register map (index of the 32-bit register, paddr[2])
   localparam logic REG_BUFFER_SIZE = 1'b0;
   localparam logic [15:0] BUFFER_SIZE_RESET = 16'hffff;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = CH_ZERO + {4'b0, nib};
      end else begin
         r = CH_LOWER_A + {4'b0, nib} - 8'd10;
      end
      return r;
   endfunction

endpackage

[rtl/core/cle_front.sv]
// ----------------------------------------------------------------------------
// cle_front: byte classifier
// Sorts each input byte into the escape kind the back end will spell out.
// ----------------------------------------------------------------------------
module cle_front (
   input  cle_pkg::req_word_type word_i,
   output cle_pkg::entry_type    entry_o
);
   import cle_pkg::*;

   logic [7:0] d;
   logic       dec_next;
   logic       hexdig;

   assign d        = word_i.data_byte;
   assign dec_next = (word_i.next_byte >= 8'h30) && (word_i.next_byte <= 8'h39);
   assign hexdig   = ((d >= 8'h30) && (d <= 8'h39)) ||
                     ((d >= 8'h61) && (d <= 8'h66)) ||
                     ((d >= 8'h41) && (d <= 8'h46));

   always_comb begin
      entry_o.value     = d;
      entry_o.zero_long = dec_next;
      entry_o.is_last   = word_i.is_last;
      case (d)
         8'h00: entry_o.kind = KIND_ZERO;
         8'h27, 8'h22, 8'h3f, 8'h5c: entry_o.kind = KIND_SPECIAL;
         8'h07: begin entry_o.kind = KIND_SPECIAL; entry_o.value = 8'h61; end
         8'h08: begin entry_o.kind = KIND_SPECIAL; entry_o.value = 8'h62; end
         8'h0c: begin entry_o.kind = KIND_SPECIAL; entry_o.value = 8'h66; end
         8'h0a: begin entry_o.kind = KIND_SPECIAL; entry_o.value = 8'h6e; end
         8'h0d: begin entry_o.kind = KIND_SPECIAL; entry_o.value = 8'h72; end
         8'h09: begin entry_o.kind = KIND_SPECIAL; entry_o.value = 8'h74; end
         8'h0b: begin entry_o.kind = KIND_SPECIAL; entry_o.value = 8'h76; end
         default: begin
            if ((d >= 8'h20) && (d <= 8'h7e)) begin
               entry_o.kind = hexdig ? KIND_PRINT_HEX : KIND_PRINT;
            end else begin
               entry_o.kind = KIND_HEX;
            end
         end
      endcase
   end

endmodule

[rtl/core/cle_queue.sv]
// ----------------------------------------------------------------------------
// cle_queue: short entry queue between front and back
// Register-based FIFO of classified entries.
// ----------------------------------------------------------------------------
module cle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_i,
   input  cle_pkg::entry_type  wr_data_i,
   output logic                full_o,
   input  logic                rd_i,
   output logic                valid_o,
   output cle_pkg::entry_type  rd_data_o
);
   import cle_pkg::*;

   localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CntW = $clog2(Q_DEPTH + 1);

   entry_type             mem_ff [Q_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full_o    = (count_ff == CntW'(Q_DEPTH));
   assign valid_o   = (count_ff != '0);
   assign rd_data_o = mem_ff[rd_ptr_ff];
   assign do_wr     = wr_i && !full_o;
   assign do_rd     = rd_i && valid_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CntW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data_i;
      end
   end

endmodule

[rtl/core/cle_back.sv]
// ----------------------------------------------------------------------------
// cle_back: escape sequencer
// Spells out one entry at a time, one character per cycle while the output
// register is free, enforces the buffer limit and appends the terminator. Ends in a one-word output register.
// ----------------------------------------------------------------------------
module cle_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           buffer_size_i,
   input  logic                  q_valid_i,
   input  cle_pkg::entry_type    q_data_i,
   output logic                  q_rd_o,
   output logic                  empty_o,
   input  logic                  pop_i,
   output cle_pkg::rsp_word_type rsp_o
);
   import cle_pkg::*;

   // current entry
   logic                b_valid_ff, b_valid_in;
   logic [7:0]          b_seq_ff [SEQ_MAX];
   logic [7:0]          seq_c    [SEQ_MAX];
   logic [2:0]          b_len_ff, len_c;
   logic [2:0]          b_pos_ff, b_pos_in;
   logic                b_last_ff;
   logic                b_hex_ff, hex_c;

   // block state
   logic                prev_hex_ff, prev_hex_in;
   logic [15:0]         cw_ff, cw_in;

   // output register
   logic                out_valid_ff;
   rsp_word_type        out_ff;

   logic [15:0]         limit;
   logic                fits, near_full, slot_free;
   logic                char_go, term_go, advance, term_emit, final_char, b_done, load;

   assign limit     = (buffer_size_i == 16'd0) ? 16'd0 : buffer_size_i - 16'd1;
   assign fits      = cw_ff < limit;
   assign near_full = !(({1'b0, cw_ff} + 17'd1) < {1'b0, limit});
   assign slot_free = !out_valid_ff || pop_i;

   assign char_go    = b_valid_ff && (b_pos_ff < b_len_ff) && fits;
   assign term_go    = b_valid_ff && !char_go && b_last_ff;
   assign advance    = char_go && slot_free;
   assign term_emit  = term_go && slot_free;
   assign final_char = !b_last_ff && (((b_pos_ff + 3'd1) == b_len_ff) || near_full);
   assign b_done     = (advance && final_char) || term_emit ||
                       (b_valid_ff && !char_go && !b_last_ff);
   assign load       = q_valid_i && (!b_valid_ff || b_done);
   assign q_rd_o     = load;

   always_comb begin
      prev_hex_in = prev_hex_ff;
      cw_in       = cw_ff;
      if (advance) begin
         cw_in = cw_ff + 16'd1;
         if (b_pos_ff == 3'd0) begin
            prev_hex_in = b_hex_ff;
         end
      end
      if (term_emit) begin
         prev_hex_in = 1'b0;
         cw_in       = 16'd0;
      end
   end

   // spell the queue head, using the hex state as it stands after this cycle
   always_comb begin
      for (int i = 0; i < SEQ_MAX; i++) begin
         seq_c[i] = CH_NUL;
      end
      len_c = 3'd1;
      hex_c = 1'b0;
      case (q_data_i.kind)
         KIND_ZERO: begin
            seq_c[0] = CH_BSLASH;
            seq_c[1] = CH_ZERO;
            seq_c[2] = CH_ZERO;
            seq_c[3] = CH_ZERO;
            len_c    = q_data_i.zero_long ? 3'd4 : 3'd2;
         end
         KIND_SPECIAL: begin
            seq_c[0] = CH_BSLASH;
            seq_c[1] = q_data_i.value;
            len_c    = 3'd2;
         end
         KIND_PRINT: begin
            seq_c[0] = q_data_i.value;
         end
         KIND_PRINT_HEX, KIND_HEX: begin
            if ((q_data_i.kind == KIND_HEX) || prev_hex_in) begin
               seq_c[0] = CH_BSLASH;
               seq_c[1] = CH_X;
               seq_c[2] = CH_ZERO;
               seq_c[3] = hex_char(q_data_i.value[7:4]);
               seq_c[4] = hex_char(q_data_i.value[3:0]);
               len_c    = 3'd5;
               hex_c    = 1'b1;
            end else begin
               seq_c[0] = q_data_i.value;
            end
         end
         default: begin
            seq_c[0] = q_data_i.value;
         end
      endcase
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_pos_in   = b_pos_ff;
      if (advance) begin
         b_pos_in = b_pos_ff + 3'd1;
      end
      if (b_done) begin
         b_valid_in = 1'b0;
      end
      if (load) begin
         b_valid_in = 1'b1;
         b_pos_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         b_pos_ff     <= 3'd0;
         prev_hex_ff  <= 1'b0;
         cw_ff        <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff  <= b_valid_in;
         b_pos_ff    <= b_pos_in;
         prev_hex_ff <= prev_hex_in;
         cw_ff       <= cw_in;
         if (advance || term_emit) begin
            out_valid_ff <= 1'b1;
         end else if (pop_i) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < SEQ_MAX; i++) begin
            b_seq_ff[i] <= seq_c[i];
         end
         b_len_ff  <= len_c;
         b_last_ff <= q_data_i.is_last;
         b_hex_ff  <= hex_c;
      end
      if (advance) begin
         out_ff.out_char      <= b_seq_ff[b_pos_ff];
         out_ff.is_terminator <= 1'b0;
         out_ff.run_last      <= final_char;
      end else if (term_emit) begin
         out_ff.out_char      <= CH_NUL;
         out_ff.is_terminator <= 1'b1;
         out_ff.run_last      <= 1'b1;
      end
   end

   assign empty_o = !out_valid_ff;
   assign rsp_o   = out_ff;

   // a terminator always closes its byte's results
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.is_terminator) |-> out_ff.run_last)
      else $error("terminator without run_last");

   // a terminator restarts the block state
   a_term_restart: assert property (@(posedge clock) disable iff (reset)
      term_emit |=> ((cw_ff == 16'd0) && !prev_hex_ff))
      else $error("block state not cleared after terminator");

   // the character pointer never runs past the spelled sequence
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_pos_ff <= b_len_ff))
      else $error("sequence pointer out of range");

   // a new entry is only taken once the previous one is finished
   a_load_order: assert property (@(posedge clock) disable iff (reset)
      (load && b_valid_ff) |-> b_done)
      else $error("entry overwritten before done");

endmodule

[rtl/core/c_string_literal_escaper.sv]
// ----------------------------------------------------------------------------
// c_string_literal_escaper: raw bytes to C string literal characters
// Each input byte becomes up to five literal characters, emitted one per
// result word; the last byte of a block also emits the closing NUL.
// ----------------------------------------------------------------------------
//
//  channel   ports                                      handshake      dir
//  --------  -----------------------------------------  -------------  ---
//  request   req_data (data_byte, next_byte, is_last)   push / full    in
//  response  rsp_data (out_char, is_terminator, run_last) pop / empty  out
//  csr       psel penable pwrite paddr pwdata prdata    APB, pready=1  in
//
//  Flow: the single-port sequencer in the back end spells one byte at a time,
//  taking the next only as the last finishes, and the terminator after a
//  block's last byte; a push passes the queue, entry and output registers.
//  Reset: synchronous, active high; buffer_size (reg 0 @ 0x0) to 65535, hex flag
//  and character count to zero.
//  Stalls: front accepts until the two-entry queue fills; back holds on a full
//  output register and resumes when pop frees it.
//
module c_string_literal_escaper (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  push,
   output logic                  full,
   input  cle_pkg::req_word_type req_data,
   // response channel
   output logic                  empty,
   input  logic                  pop,
   output cle_pkg::rsp_word_type rsp_data,
   // csr port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import cle_pkg::*;

   // buffer_size register
   logic [15:0]  buffer_size_ff;
   logic         csr_wr;

   // front -> queue -> back
   entry_type    front_entry;
   entry_type    q_head;
   logic         q_valid;
   logic         q_rd;
   logic         q_full;

   assign pready = 1'b1;
   // paddr[1:0] are byte lanes; paddr[2] selects the word
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_SIZE);
   assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? {16'd0, buffer_size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= BUFFER_SIZE_RESET;
      end else if (csr_wr) begin
         buffer_size_ff <= pwdata[15:0];
      end
   end

   // classify the incoming byte
   cle_front u_front (
      .word_i  (req_data),
      .entry_o (front_entry)
   );

   // decouple classification from emission
   cle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_i      (push),
      .wr_data_i (front_entry),
      .full_o    (q_full),
      .rd_i      (q_rd),
      .valid_o   (q_valid),
      .rd_data_o (q_head)
   );

   assign full = q_full;

   // spell out characters, count them against the buffer, add terminator
   cle_back u_back (
      .clock         (clock),
      .reset         (reset),
      .buffer_size_i (buffer_size_ff),
      .q_valid_i     (q_valid),
      .q_data_i      (q_head),
      .q_rd_o        (q_rd),
      .empty_o       (empty),
      .pop_i         (pop),
      .rsp_o         (rsp_data)
   );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the C string literal escaper
// Queues blocks of raw bytes into the request side, predicts every literal
// character in order, and checks each popped response word field by field.
// The buffer size register is rewritten between traffic bursts, including
// zero, one, small sizes and the reset maximum.
// ----------------------------------------------------------------------------
module tb_top;
   import cle_pkg::*;

   localparam int       WATCHDOG_LIMIT = 1000;  // cycles with no word moved
   localparam int       SETTLE_CYCLES  = 16;    // covers items that emit nothing
   localparam int       PHASE_ITEMS    = 150;
   localparam logic [2:0] CSR_BUFFER_SIZE = {REG_BUFFER_SIZE, 2'b00};

   // opening block: zeros before a digit and a non-digit, all eleven named
   // escapes, a hex byte then a hex digit, space, tilde, closing zero
   localparam int          OPENING_LEN = 20;
   localparam logic [8*OPENING_LEN-1:0] OPENING_BYTES = {
      8'h00, 8'h37, 8'h00, 8'h78, 8'h27, 8'h22, 8'h3f, 8'h5c, 8'h07, 8'h08,
      8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b, 8'hff, 8'h42, 8'h20, 8'h7e, 8'h00};

   logic         clock   = 1'b0;
   logic         reset   = 1'b1;
   logic         push    = 1'b0;
   logic         full;
   req_word_type req_data = '0;
   logic         empty;
   logic         pop     = 1'b0;
   rsp_word_type rsp_data;
   logic         psel    = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite  = 1'b0;
   logic [2:0]   paddr   = '0;
   logic [31:0]  pwdata  = '0;
   logic [31:0]  prdata;
   logic         pready;

   c_string_literal_escaper uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   req_word_type req_backlog[$];     // words waiting for the driver
   rsp_word_type expected_chars[$];  // predicted literal characters, oldest first
   logic [7:0]   block_bytes[$];     // raw bytes of the block being built
   int           bytes_queued = 0;
   int           bytes_taken  = 0;
   int           mismatch_count = 0;
   int           idle_cycles  = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   logic         req_fire = 1'b0;    // push word taken at the last rising edge

   // predictor copy of the block: register and per-block state
   logic [15:0]  buf_size   = BUFFER_SIZE_RESET;
   bit           hex_run    = 1'b0;  // last byte went out as \x0hh
   int           char_count = 0;     // characters emitted in this block

   // ------------------------------------------------------------------
   // Predictor helpers
   // ------------------------------------------------------------------
   function automatic bit is_decimal(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // name letter of a backslash escape, NUL when the byte has none
   function automatic logic [7:0] escape_name(input logic [7:0] c);
      case (c)
         8'h27, 8'h22, 8'h3f, 8'h5c: return c;
         8'h07:   return "a";
         8'h08:   return "b";
         8'h0c:   return "f";
         8'h0a:   return "n";
         8'h0d:   return "r";
         8'h09:   return "t";
         8'h0b:   return "v";
         default: return CH_NUL;
      endcase
   endfunction

   // lower-case hex digit; 39 skips the gap from '9'+1 up to 'a'
   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      return CH_ZERO + {4'b0, n} + ((n > 4'd9) ? 8'd39 : 8'd0);
   endfunction

   // spell one input byte and append the resulting words to expected_chars
   task automatic escape_byte(input req_word_type w);
      logic [7:0] spell [5];
      logic [7:0] ch [6];
      logic       term [6];
      logic [7:0] name;
      int         len;
      int         cnt;
      int         limit;
      bit         hex_now;
      bit         hexdig;
      len     = 0;
      cnt     = 0;
      hex_now = 1'b0;
      // size zero acts as one: room for the terminator only
      limit   = (buf_size == 16'd0) ? 0 : int'(buf_size) - 1;
      name    = escape_name(w.data_byte);
      hexdig  = is_decimal(w.data_byte) ||
                (w.data_byte >= "a" && w.data_byte <= "f") ||
                (w.data_byte >= "A" && w.data_byte <= "F");
      if (char_count < limit) begin
         if (w.data_byte == CH_NUL) begin
            spell[0] = CH_BSLASH;
            spell[1] = CH_ZERO;
            len = 2;
            // a digit after the zero would extend the octal escape
            if (is_decimal(w.next_byte)) begin
               spell[2] = CH_ZERO;
               spell[3] = CH_ZERO;
               len = 4;
            end
         end else if (name != CH_NUL) begin
            spell[0] = CH_BSLASH;
            spell[1] = name;
            len = 2;
         end else if (w.data_byte >= 8'h20 && w.data_byte <= 8'h7e && !(hex_run && hexdig)) begin
            spell[0] = w.data_byte;
            len = 1;
         end else begin
            spell[0] = CH_BSLASH;
            spell[1] = CH_X;
            spell[2] = CH_ZERO;
            spell[3] = nibble_char(w.data_byte[7:4]);
            spell[4] = nibble_char(w.data_byte[3:0]);
            len = 5;
            hex_now = 1'b1;
         end
         // an escape that runs past the buffer is cut short
         for (int k = 0; k < len && char_count < limit; k++) begin
            ch[cnt]   = spell[k];
            term[cnt] = 1'b0;
            cnt++;
            char_count++;
         end
         hex_run = hex_now;
      end
      // terminator always goes out, even on a full buffer
      if (w.is_last) begin
         ch[cnt]   = CH_NUL;
         term[cnt] = 1'b1;
         cnt++;
         hex_run    = 1'b0;
         char_count = 0;
      end
      for (int k = 0; k < cnt; k++) begin
         expected_chars.push_back({ch[k], term[k], (k == cnt - 1)});
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // mix weighted toward the interesting classes
   function automatic logic [7:0] pick_byte();
      logic [7:0] specials [11];
      specials = '{8'h27, 8'h22, 8'h3f, 8'h5c, 8'h07, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b};
      case ($urandom_range(7))
         0:       return CH_NUL;
         1:       return specials[$urandom_range(10)];
         2:       return 8'h30 + 8'($urandom_range(9));
         3:       return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(5));
         4:       return 8'h80 + 8'($urandom_range(127));
         5:       return 8'h20 + 8'($urandom_range(94));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [15:0] pick_size();
      case ($urandom_range(7))
         0:       return 16'd1;
         1:       return 16'd2;
         2:       return 16'd3;
         3:       return BUFFER_SIZE_RESET;
         4:       return 16'($urandom_range(65535));
         default: return 16'($urandom_range(4, 30));
      endcase
   endfunction

   // turn block_bytes into request words; an open block gets no is_last so
   // the next burst carries on with the same character count
   task automatic queue_block(input bit open_end, input bit noisy);
      req_word_type w;
      int           n;
      n = block_bytes.size();
      for (int i = 0; i < n; i++) begin
         w.data_byte = block_bytes[i];
         w.next_byte = (i < n - 1) ? block_bytes[i + 1] : CH_NUL;
         if (noisy && $urandom_range(3) == 0) begin
            w.next_byte = 8'($urandom_range(255));
         end
         w.is_last = (i == n - 1) && !open_end;
         req_backlog.push_back(w);
         bytes_queued++;
      end
      block_bytes.delete();
   endtask

   // hold off until every queued byte is taken and every word has come back
   task automatic wait_idle();
      while (bytes_taken != bytes_queued || expected_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write: setup then access, register lands on the access edge
   task automatic write_buffer_size(input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_BUFFER_SIZE;
      pwdata  <= {16'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic random_bursts(input int count);
      int target;
      int len;
      target = bytes_queued + count;
      while (bytes_queued < target) begin
         if ($urandom_range(2) == 0) begin
            wait_idle();
            write_buffer_size(pick_size());
         end
         repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            repeat (len) block_bytes.push_back(pick_byte());
            queue_block($urandom_range(9) == 0, $urandom_range(9) == 0);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: request side, changes on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_fire) begin
         // previous word gone (or none offered): offer the next or idle
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            push     <= 1'b1;
            req_data <= req_backlog.pop_front();
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver side stalls at its own rate
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: samples on the rising edge, predicts and checks
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         req_fire    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= push && !full;
         if (psel && penable && pwrite && pready && paddr == CSR_BUFFER_SIZE) begin
            buf_size = pwdata[15:0];
         end
         if (push && !full) begin
            escape_byte(req_data);
            bytes_taken++;
         end
         if (pop && !empty) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  $display("%0t: out_char expected %h got %h",
                           $time, want.out_char, rsp_data.out_char);
                  mismatch_count++;
               end
               if (rsp_data.is_terminator !== want.is_terminator) begin
                  $display("%0t: is_terminator expected %b got %b",
                           $time, want.is_terminator, rsp_data.is_terminator);
                  mismatch_count++;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %b got %b",
                           $time, want.run_last, rsp_data.run_last);
                  mismatch_count++;
               end
            end
         end
         // watchdog only runs while traffic is outstanding
         if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
         end else if (bytes_taken != bytes_queued || expected_chars.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: full spelling table at the reset size
      send_idle_pct = 6;
      recv_idle_pct = 57;
      for (int i = OPENING_LEN - 1; i >= 0; i--) begin
         block_bytes.push_back(OPENING_BYTES[8*i +: 8]);
      end
      queue_block(1'b0, 1'b0);

      // hex escape cut off after three characters, then the terminator
      wait_idle();
      write_buffer_size(16'd4);
      block_bytes.push_back(8'hff);
      queue_block(1'b0, 1'b0);

      // size zero: terminator only
      wait_idle();
      write_buffer_size(16'd0);
      block_bytes.push_back("q");
      queue_block(1'b0, 1'b0);

      // fill a size-3 buffer; third byte emits nothing
      wait_idle();
      write_buffer_size(16'd3);
      block_bytes.push_back("a");
      block_bytes.push_back("b");
      block_bytes.push_back("c");
      queue_block(1'b1, 1'b0);

      // shrink below the count mid-block: only the terminator follows
      wait_idle();
      write_buffer_size(16'd2);
      block_bytes.push_back("d");
      queue_block(1'b0, 1'b0);

      // random bursts under three idle profiles
      random_bursts(PHASE_ITEMS);
      wait_idle();
      send_idle_pct = 57;
      recv_idle_pct = 6;
      random_bursts(PHASE_ITEMS);
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_bursts(PHASE_ITEMS);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
